@@ rtl/sws_pkg.sv @@
// Package for the LIFO stack with depth search.
// Holds the word types, operation and status codes, and the cell shift modes.
// No dependencies.
package sws_pkg;

    typedef logic signed [31:0] t_data;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_FIND = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // cell load select: keep, take neighbor nearer the top, take neighbor farther down
    typedef enum logic [1:0] {
        SH_HOLD      = 2'd0,
        SH_FROM_UP   = 2'd1,
        SH_FROM_DOWN = 2'd2
    } t_shift;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_FIND = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        t_op   operation;
        t_data value;
    } t_in_word;

    typedef struct packed {
        t_data      popped_value;
        logic       found;
        logic [7:0] position;
        t_status    status;
    } t_out_word;

endpackage

@@ rtl/sws_cell.sv @@
// One storage cell of the stack chain.
// Loads from its upper or lower neighbor or holds, as the shift mode says.
// Depends on sws_pkg.
module sws_cell (
    input  logic            i_clk,
    input  sws_pkg::t_shift i_shift,
    input  sws_pkg::t_data  i_from_up,
    input  sws_pkg::t_data  i_from_down,
    output sws_pkg::t_data  o_data
);
    import sws_pkg::*;

    t_data r_data;
    t_data n_data;

    always_comb begin
        unique case (i_shift)
            SH_HOLD:      n_data = r_data;
            SH_FROM_UP:   n_data = i_from_up;
            SH_FROM_DOWN: n_data = i_from_down;
            default:      n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

@@ rtl/stack_with_depth_search.sv @@
// Top level of the LIFO stack with depth search: control FSM and the cell chain.
// Instantiates DEPTH copies of sws_cell.
// Depends on sws_pkg.
//
//  channel | valid       | stall       | word
//  --------+-------------+-------------+------------------------------------
//  input   | i_in_valid  | o_in_stall  | i_in_word  (operation, value)
//  output  | o_out_valid | i_out_stall | o_out_word (popped_value, found,
//          |             |             |             position, status)
//
// Push, pop, a find on an empty stack and an unused opcode write their result
// straight into the output register. A find on a non-empty stack rotates the
// whole ring of DEPTH cells once past the top cell, one cell per cycle, then
// waits in the done state until the output register has room.
// Reset: synchronous, active low; clears the fill count and the control state.
// Cell contents are not reset.
// Stalls: a new word is taken only in idle while the output register is
// empty or being drained; a finished find waits for the output register.
module stack_with_depth_search #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  sws_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output sws_pkg::t_out_word o_out_word
);
    import sws_pkg::*;

    localparam int CW = $clog2(DEPTH);      // rotation step counter
    localparam int FW = $clog2(DEPTH + 1);  // fill count, holds DEPTH itself

    // control state
    t_state         r_state, n_state;
    logic [FW-1:0]  r_fill, n_fill;
    logic [CW-1:0]  r_step, n_step;
    logic           r_found, n_found;
    logic           r_out_valid, n_out_valid;

    // payload
    t_data          r_key, n_key;
    logic [7:0]     r_pos, n_pos;
    t_out_word      r_out, n_out;

    t_shift         w_shift;
    t_data          w_cell [DEPTH];
    logic           w_accept;
    logic           w_out_free;
    logic [CW:0]    w_pops;

    // Input taken only from idle with room in the output register.
    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;

    // pops needed to bring the cell now at the top out of the original stack
    assign w_pops = {1'b0, r_step} + (CW + 1)'(1);

    // Cell chain. Cell 0 is the top of the stack. Push shifts everything one
    // cell down; pop and the find rotation shift everything one cell up, the
    // last cell taking the top word so a full rotation restores the stack.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int UP = (g == 0) ? 0 : g - 1;
        localparam int DN = (g == DEPTH - 1) ? 0 : g + 1;
        t_data w_up;
        assign w_up = (g == 0) ? i_in_word.value : w_cell[UP];
        sws_cell u_cell (
            .i_clk       (i_clk),
            .i_shift     (w_shift),
            .i_from_up   (w_up),
            .i_from_down (w_cell[DN]),
            .o_data      (w_cell[g])
        );
    end

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_step      = r_step;
        n_found     = r_found;
        n_key       = r_key;
        n_pos       = r_pos;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;
        w_shift     = SH_HOLD;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out       = '0;
                    n_out.status = ST_OK;
                    n_out_valid = 1'b1;
                    unique case (i_in_word.operation)
                        OP_PUSH: begin
                            if (r_fill == FW'(DEPTH)) begin
                                n_out.status = ST_OVERFLOW;
                            end else begin
                                w_shift = SH_FROM_UP;
                                n_fill  = r_fill + FW'(1);
                            end
                        end
                        OP_POP: begin
                            if (r_fill == '0) begin
                                n_out.status = ST_UNDERFLOW;
                            end else begin
                                w_shift            = SH_FROM_DOWN;
                                n_fill             = r_fill - FW'(1);
                                n_out.popped_value = w_cell[0];
                            end
                        end
                        OP_FIND: begin
                            if (r_fill == '0) begin
                                n_out.status = ST_EMPTY;
                            end else begin
                                // result comes at the end of the rotation
                                n_out_valid = 1'b0;
                                n_state     = S_FIND;
                                n_key       = i_in_word.value;
                                n_step      = '0;
                                n_found     = 1'b0;
                                n_pos       = '0;
                            end
                        end
                        default: begin
                            // unused opcode: all-zero result, stack untouched
                        end
                    endcase
                end
            end
            S_FIND: begin
                // top cell now holds the entry that was r_step cells down;
                // only entries below the fill count are live
                w_shift = SH_FROM_DOWN;
                if (!r_found && (FW'(r_step) < r_fill) && (w_cell[0] == r_key)) begin
                    n_found = 1'b1;
                    n_pos   = 8'(w_pops);
                end
                if (r_step == CW'(DEPTH - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step + CW'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out.popped_value = '0;
                    n_out.found        = r_found;
                    n_out.position     = r_pos;
                    n_out.status       = ST_OK;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_step      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_step      <= n_step;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pos <= n_pos;
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    // fill count never passes the chain length
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(DEPTH))
        else $error("fill count above depth");

    // no new word while a find rotates or waits to report
    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input open while busy");

    // an accepted push onto a non-full stack grows it by one
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_in_word.operation == OP_PUSH) && (r_fill != FW'(DEPTH)))
        |=> (r_fill == $past(r_fill) + FW'(1)))
        else $error("push did not grow the stack");

    // a finished find reports as soon as the output register has room
    a_find_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && w_out_free) |=> (o_out_valid && (r_state == S_IDLE)))
        else $error("find result not delivered");

endmodule

@@ bench/stack_result_checker.sv @@
`timescale 1ns / 100ps
// Result checker for the LIFO stack with depth search: watches both word channels,
// keeps its own copy of the stack and compares every result word. Depends on sws_pkg.
module stack_result_checker #(
    parameter int DEPTH = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  sws_pkg::t_in_word  i_in_word,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  sws_pkg::t_out_word i_out_word,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_word_count,
    output int                 o_hit_count,
    output int                 o_overflow_count,
    output int                 o_underflow_count,
    output int                 o_empty_count
);
    import sws_pkg::*;

    t_data     model_words [DEPTH];   // entry 0 is the bottom
    int        model_fill = 0;
    t_out_word pending_results [$];

    int fails = 0;
    int words = 0;
    int hits = 0;
    int overflows = 0;
    int underflows = 0;
    int empties = 0;

    // Applies one operation to the stack copy and returns the result word it gives.
    function automatic t_out_word apply_stack_op(input t_in_word w);
        t_out_word r;
        int        idx;
        r = '0;
        r.status = ST_OK;
        case (w.operation)
            OP_PUSH: begin
                if (model_fill >= DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_words[model_fill] = w.value;
                    model_fill++;
                end
            end
            OP_POP: begin
                if (model_fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    model_fill--;
                    r.popped_value = model_words[model_fill];
                end
            end
            OP_FIND: begin
                if (model_fill == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // top down, first match wins; position is the low 8 bits of the pop count
                    for (idx = model_fill - 1; idx >= 0 && !r.found; idx--) begin
                        if (model_words[idx] == w.value) begin
                            r.found    = 1'b1;
                            r.position = 8'(model_fill - idx);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            model_fill = 0;
            pending_results.delete();
        end else begin
            // result side first: the output register always holds an older word
            if (i_out_valid && !i_out_stall) begin
                words++;
                if (pending_results.size() == 0) begin
                    $error("result word arrived with nothing expected");
                    fails++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_word.popped_value !== want.popped_value) begin
                        $error("popped_value: expected %0d, actual %0d",
                               want.popped_value, i_out_word.popped_value);
                        fails++;
                    end
                    if (i_out_word.found !== want.found) begin
                        $error("found: expected %0d, actual %0d",
                               want.found, i_out_word.found);
                        fails++;
                    end
                    if (i_out_word.position !== want.position) begin
                        $error("position: expected %0d, actual %0d",
                               want.position, i_out_word.position);
                        fails++;
                    end
                    if (i_out_word.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, i_out_word.status);
                        fails++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = apply_stack_op(i_in_word);
                case (want.status)
                    ST_OVERFLOW:  overflows++;
                    ST_UNDERFLOW: underflows++;
                    ST_EMPTY:     empties++;
                    default: begin
                    end
                endcase
                if (want.found) begin
                    hits++;
                end
                pending_results.push_back(want);
            end
        end
        o_fail_count      <= fails;
        o_pending         <= pending_results.size();
        o_word_count      <= words;
        o_hit_count       <= hits;
        o_overflow_count  <= overflows;
        o_underflow_count <= underflows;
        o_empty_count     <= empties;
    end

endmodule

@@ bench/stack_with_depth_search_tb.sv @@
`timescale 1ns / 100ps
// Top of the stack_with_depth_search bench: clock, reset, word stimulus and verdict.
// Instantiates the block and stack_result_checker; depends on sws_pkg.
module stack_with_depth_search_tb;
    import sws_pkg::*;

    localparam int DEPTH      = 128;
    localparam int RAND_WORDS = 500;  // random words sent, unused opcode not counted
    localparam int IDLE_PCT   = 28;   // chance per cycle that a side idles

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_word  in_word = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_word out_word;
    logic      steady = 1'b0;     // while set neither side idles

    int chk_fails;
    int chk_pending;
    int chk_words;
    int chk_hits;
    int chk_overflows;
    int chk_underflows;
    int chk_empties;

    // What the stimulus believes is stacked, bottom first. Only used to steer
    // the choice of operations and find keys; results come from the checker.
    t_data mirror [$];
    int    real_words = 0;        // words sent other than the unused opcode

    stack_with_depth_search #(
        .DEPTH(DEPTH)
    ) DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_word  (in_word),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_word (out_word)
    );

    stack_result_checker #(
        .DEPTH(DEPTH)
    ) checker_0 (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_in_word        (in_word),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_word       (out_word),
        .o_fail_count     (chk_fails),
        .o_pending        (chk_pending),
        .o_word_count     (chk_words),
        .o_hit_count      (chk_hits),
        .o_overflow_count (chk_overflows),
        .o_underflow_count(chk_underflows),
        .o_empty_count    (chk_empties)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Receiver: random stalls, none while the steady stretch runs.
    always @(posedge clk) begin
        if (steady) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Sends one word: random idle cycles first, then holds it until taken.
    // in_stall is read right after the edge, so it is the value that edge saw.
    task automatic send_word(input t_op op, input t_data val);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= '{operation: op, value: val};
        do @(posedge clk); while (in_stall);
        case (op)
            OP_PUSH: begin
                if (mirror.size() < DEPTH) begin
                    mirror.push_back(val);
                end
            end
            OP_POP: begin
                if (mirror.size() > 0) begin
                    void'(mirror.pop_back());
                end
            end
            default: begin
            end
        endcase
        if (op != OP_NONE) begin
            real_words++;
        end
    endtask

    // Push data: small values give duplicates, plus the signed extremes.
    function automatic t_data pick_push_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return t_data'($urandom_range(0, 7));
        end
        if (r < 50) begin
            case ($urandom_range(0, 3))
                0:       return t_data'(32'h8000_0000);
                1:       return t_data'(32'h7fff_ffff);
                2:       return '0;
                default: return '1;
            endcase
        end
        return t_data'($urandom);
    endfunction

    // Find keys: mostly words known to be stacked, so finds hit at any depth.
    function automatic t_data pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65 && mirror.size() > 0) begin
            return mirror[$urandom_range(0, mirror.size() - 1)];
        end
        if (r < 80) begin
            return t_data'($urandom_range(0, 7));
        end
        return t_data'($urandom);
    endfunction

    // One random word; what is left after push and pop goes mostly to finds.
    task automatic send_random(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct) begin
            send_word(OP_PUSH, pick_push_value());
        end else if (r < push_pct + pop_pct) begin
            send_word(OP_POP, t_data'($urandom));
        end else if (r < 96) begin
            send_word(OP_FIND, pick_key());
        end else begin
            send_word(OP_NONE, t_data'($urandom));
        end
    endtask

    initial begin
        int base;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-stack cases, unused opcode, signed extremes,
        // duplicates, find at top, bottom and miss, then drain to underflow.
        send_word(OP_POP,  t_data'(32'h1234_5678));
        send_word(OP_FIND, '0);
        send_word(OP_NONE, '1);
        send_word(OP_PUSH, t_data'(32'h8000_0000));
        send_word(OP_PUSH, t_data'(32'h7fff_ffff));
        send_word(OP_PUSH, '0);
        send_word(OP_PUSH, '1);
        send_word(OP_PUSH, t_data'(5));
        send_word(OP_PUSH, t_data'(5));
        send_word(OP_FIND, t_data'(5));
        send_word(OP_FIND, t_data'(32'h8000_0000));
        send_word(OP_FIND, t_data'(12345));
        send_word(OP_FIND, t_data'(32'h7fff_ffff));
        send_word(OP_NONE, t_data'(32'h5555_aaaa));
        send_word(OP_POP,  '0);
        send_word(OP_FIND, t_data'(5));
        repeat (5) send_word(OP_POP, '1);
        send_word(OP_POP,  '0);
        send_word(OP_FIND, '1);

        // Random: a balanced mix, then a no-idle stretch that fills the
        // stack past full, works near the top, drains it past empty, then mixes again.
        base = real_words;
        while (real_words - base < 100) send_random(40, 30);
        steady <= 1'b1;
        while (mirror.size() < DEPTH) send_random(80, 6);
        send_word(OP_FIND, mirror[0]);
        repeat (4) send_word(OP_PUSH, pick_push_value());
        repeat (40) send_random(35, 35);
        while (mirror.size() > 0) send_random(6, 80);
        repeat (3) send_word(OP_POP, t_data'($urandom));
        steady <= 1'b0;
        while (real_words - base < RAND_WORDS) send_random(40, 30);
        in_valid <= 1'b0;

        // Let the checker count the last word, drain, then allow one full find.
        @(posedge clk);
        while (chk_pending != 0) @(posedge clk);
        repeat (DEPTH + 4) @(posedge clk);

        $display("checked %0d result words from %0d operations; %0d finds matched",
                 chk_words, real_words, chk_hits);
        $display("status coverage: %0d overflow, %0d underflow, %0d find on empty",
                 chk_overflows, chk_underflows, chk_empties);
        if (chk_fails == 0 && chk_pending == 0) begin
            $display("stack_with_depth_search regression: pass");
        end else begin
            $display("stack_with_depth_search regression: fail");
        end
        $finish;
    end

    // Watchdog: far beyond a run where every word is a full-depth find.
    initial begin
        #6_000_000;
        $error("run did not complete in the time allowed");
        $display("stack_with_depth_search regression: fail");
        $finish;
    end

endmodule
